### src/brme_pkg.sv
// shared types, register map and constants for the border mask erosion block
package brme_pkg;

  // default geometry
  localparam int DEF_KERNEL_SIZE = 21;
  localparam int DEF_MAX_WIDTH   = 2048;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_MARGIN_TOP    = 3'd2,
    REG_MARGIN_BOTTOM = 3'd3,
    REG_MARGIN_LEFT   = 3'd4,
    REG_MARGIN_RIGHT  = 3'd5,
    REG_COLOR_INPUT   = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;

  // item opcodes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  // bt.601 gray weights, 14 fractional bits
  localparam int GRAY_SUM_W   = 22;
  localparam int GRAY_FRAC    = 14;
  localparam int GRAY_COEF_B  = 1868;
  localparam int GRAY_COEF_G  = 9617;
  localparam int GRAY_COEF_R  = 4899;
  localparam int GRAY_ROUND   = 8192;

  // input row counter saturates here
  localparam int IN_ROW_W   = 13;
  localparam int IN_ROW_MAX = 8191;

  localparam logic [7:0] MASK_ON  = 8'd255;
  localparam logic [7:0] MASK_OFF = 8'd0;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] blue_or_gray;
    logic [7:0] green_value;
    logic [7:0] red_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mask_value;
    logic [10:0] out_column;
    logic [11:0] out_row;
    logic        frame_done;
  } out_item_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [11:0] margin_top;
    logic [11:0] margin_bottom;
    logic [10:0] margin_left;
    logic [10:0] margin_right;
    logic        color_input;
  } cfg_t;

endpackage

### src/brme_apb_regs.sv
// configuration register file behind the apb-style port
module brme_apb_regs
  import brme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  cfg_reg_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= RST_FRAME_WIDTH;
      cfg_r.frame_height  <= RST_FRAME_HEIGHT;
      cfg_r.margin_top    <= '0;
      cfg_r.margin_bottom <= '0;
      cfg_r.margin_left   <= '0;
      cfg_r.margin_right  <= '0;
      cfg_r.color_input   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:   cfg_r.frame_width   <= pwdata[11:0];
        REG_FRAME_HEIGHT:  cfg_r.frame_height  <= pwdata[11:0];
        REG_MARGIN_TOP:    cfg_r.margin_top    <= pwdata[11:0];
        REG_MARGIN_BOTTOM: cfg_r.margin_bottom <= pwdata[11:0];
        REG_MARGIN_LEFT:   cfg_r.margin_left   <= pwdata[10:0];
        REG_MARGIN_RIGHT:  cfg_r.margin_right  <= pwdata[10:0];
        REG_COLOR_INPUT:   cfg_r.color_input   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:   prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT:  prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_MARGIN_TOP:    prdata = CFG_DATA_W'(cfg_r.margin_top);
      REG_MARGIN_BOTTOM: prdata = CFG_DATA_W'(cfg_r.margin_bottom);
      REG_MARGIN_LEFT:   prdata = CFG_DATA_W'(cfg_r.margin_left);
      REG_MARGIN_RIGHT:  prdata = CFG_DATA_W'(cfg_r.margin_right);
      REG_COLOR_INPUT:   prdata = CFG_DATA_W'(cfg_r.color_input);
      default:           prdata = '0;
    endcase
  end

endmodule

### src/brme_col_ram.sv
// column run counter ram, one write and one registered read per cycle
module brme_col_ram
  import brme_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH),
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/border_roi_mask_erosion.sv
// top level: margin rectangle mask with square erosion over a raster pixel stream
//
// Takes one pixel or flush transaction per clock while in_stall is low and gives
// at most one mask transaction per clock. Each pixel does one read and one write
// of the column run counter RAM (MAX_WIDTH entries), split over two stages with
// forwarding for back-to-back hits on the same column, so the sustained rate is
// one item per cycle while out_stall is low; a finished result waits in the
// output register while the next pixel is taken. The result for pixel p of a
// frame comes out on the transaction numbered p + B*width + min(B, width-1), B =
// KERNEL_SIZE-1-KERNEL_SIZE/2 (10 for a 21x21 window), and is registered in s1
// and then the output register after that item is accepted; flush transactions
// after the last pixel push the tail out. After reset the RAM is swept to the
// saturated count, one entry a clock, over all MAX_WIDTH entries while in_stall
// stays high; configuration writes are taken throughout.
module border_roi_mask_erosion
  import brme_pkg::*;
#(
  parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // mask output
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = ((WW > 12) ? WW : 12) + 2;
  localparam int RW   = $clog2(KERNEL_SIZE + 1);
  localparam int BACK = KERNEL_SIZE - 1 - KERNEL_SIZE / 2;

  localparam logic [RW-1:0] RUN_FULL = RW'(KERNEL_SIZE);
  localparam logic [CW-1:0] BACK_C   = CW'(BACK);
  localparam logic [CW-1:0] MAXW_C   = CW'(MAX_WIDTH);

  cfg_t cfg;

  brme_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // position state
  logic [AW-1:0]       ic_r, ic_nxt;
  logic [IN_ROW_W-1:0] ir_r, ir_nxt;
  logic [AW-1:0]       oc_r, oc_nxt;
  logic [11:0]         ro_r, ro_nxt;

  // ram clearing sweep
  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // second stage
  logic          s1_valid_r, s1_valid_nxt;
  logic [AW-1:0] s1_addr_r;
  logic          s1_bit_r, s1_first_row_r, s1_first_col_r, s1_last_col_r;
  logic          s1_emit_r, s1_use_cur_r, s1_done_r;
  logic [RW-1:0] s1_need_r;
  logic [AW-1:0] s1_oc_r;
  logic [11:0]   s1_ro_r;
  logic          fwd_hit_r;
  logic [RW-1:0] fwd_data_r;

  // horizontal runs
  logic [RW-1:0] row_run_r, row_end_r;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // first stage signals
  logic [CW-1:0]         w_eff, w_last, h_eff, h_last;
  logic [CW-1:0]         ic_x, ic_c, oc_c, ir_x, ro_x;
  logic                  padding, skip, accept, take;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic                  gray_nz, in_rect, pix_bit, emit, done, use_cur;
  logic [CW-1:0]         d_lim, reach, over;
  logic [RW-1:0]         need;

  // second stage signals
  logic          s1_blocked, s1_adv;
  logic [RW-1:0] col_prev, col_new, row_prev, row_new, run_sel;
  logic [RW-1:0] ram_rd_data;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [RW-1:0] ram_wr_data;

  // effective frame size
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(cfg.frame_width) > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = CW'(cfg.frame_width);
    end
    h_eff  = (cfg.frame_height == '0) ? CW'(1) : CW'(cfg.frame_height);
    w_last = w_eff - CW'(1);
    h_last = h_eff - CW'(1);
  end

  // handshake
  assign s1_blocked = s1_valid_r && s1_emit_r && out_valid_r && out_stall;
  assign s1_adv     = s1_valid_r && !s1_blocked;
  assign in_stall   = clr_active_r || s1_blocked;
  assign accept     = in_valid && !in_stall;
  assign take       = accept && !skip;

  // pixel classification and window bookkeeping
  always_comb begin
    ic_x    = CW'(ic_r);
    ic_c    = (ic_x >= w_eff) ? w_last : ic_x;
    oc_c    = (CW'(oc_r) >= w_eff) ? w_last : CW'(oc_r);
    ir_x    = CW'(ir_r);
    ro_x    = CW'(ro_r);
    padding = ir_x >= h_eff;
    skip    = (in_data.opcode == OP_FLUSH) && !padding;

    gray_sum = GRAY_SUM_W'(in_data.blue_or_gray) * GRAY_SUM_W'(GRAY_COEF_B)
             + GRAY_SUM_W'(in_data.green_value) * GRAY_SUM_W'(GRAY_COEF_G)
             + GRAY_SUM_W'(in_data.red_value) * GRAY_SUM_W'(GRAY_COEF_R)
             + GRAY_SUM_W'(GRAY_ROUND);
    gray_nz  = cfg.color_input ? (gray_sum[GRAY_SUM_W-1:GRAY_FRAC] != '0)
                               : (in_data.blue_or_gray != '0);

    in_rect = (ic_c >= CW'(cfg.margin_left))
           && (ic_c + CW'(cfg.margin_right) < w_eff)
           && (ir_x >= CW'(cfg.margin_top))
           && (ir_x + CW'(cfg.margin_bottom) < h_eff);
    pix_bit = padding || (in_rect && gray_nz);

    d_lim   = (BACK_C < w_last) ? BACK_C : w_last;
    emit    = (ir_x > BACK_C) || ((ir_x == BACK_C) && (ic_c >= d_lim));
    reach   = oc_c + BACK_C;
    over    = (reach > w_last) ? (reach - w_last) : '0;
    need    = RUN_FULL - RW'(over);
    use_cur = ir_x == (ro_x + BACK_C);
    done    = (oc_c >= w_last) && (ro_x >= h_last);
  end

  // next positions
  always_comb begin
    ic_nxt = ic_r;
    ir_nxt = ir_r;
    oc_nxt = oc_r;
    ro_nxt = ro_r;
    if (take) begin
      if (ic_c >= w_last) begin
        ic_nxt = '0;
        ir_nxt = (ir_r < IN_ROW_W'(IN_ROW_MAX)) ? (ir_r + IN_ROW_W'(1)) : ir_r;
      end else begin
        ic_nxt = AW'(ic_c + CW'(1));
      end
      oc_nxt = AW'(oc_c);
      if (emit) begin
        if (done) begin
          ic_nxt = '0;
          ir_nxt = '0;
          oc_nxt = '0;
          ro_nxt = '0;
        end else if (oc_c >= w_last) begin
          oc_nxt = '0;
          ro_nxt = ro_r + 12'd1;
        end else begin
          oc_nxt = AW'(oc_c + CW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0;
      ir_r <= '0;
      oc_r <= '0;
      ro_r <= '0;
    end else begin
      ic_r <= ic_nxt;
      ir_r <= ir_nxt;
      oc_r <= oc_nxt;
      ro_r <= ro_nxt;
    end
  end

  // clearing sweep after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // column counter ram
  assign ram_wr_en   = clr_active_r || s1_adv;
  assign ram_wr_addr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clr_active_r ? RUN_FULL : col_new;

  brme_col_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (RW)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (take),
    .rd_addr (AW'(ic_c)),
    .rd_data (ram_rd_data)
  );

  // stage one valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (take) begin
        fwd_hit_r <= s1_adv && (s1_addr_r == AW'(ic_c));
      end
    end
  end

  // stage one payload, loaded with the ram read
  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r      <= AW'(ic_c);
      s1_bit_r       <= pix_bit;
      s1_first_row_r <= (ir_r == '0);
      s1_first_col_r <= (ic_c == '0);
      s1_last_col_r  <= (ic_c == w_last);
      s1_emit_r      <= emit;
      s1_need_r      <= need;
      s1_use_cur_r   <= use_cur;
      s1_done_r      <= done;
      s1_oc_r        <= AW'(oc_c);
      s1_ro_r        <= ro_r;
      fwd_data_r     <= col_new;
    end
  end

  // vertical and horizontal run update
  always_comb begin
    if (s1_first_row_r) begin
      col_prev = RUN_FULL;
    end else if (fwd_hit_r) begin
      col_prev = fwd_data_r;
    end else begin
      col_prev = ram_rd_data;
    end
    if (!s1_bit_r) begin
      col_new = '0;
    end else if (col_prev >= RUN_FULL - RW'(1)) begin
      col_new = RUN_FULL;
    end else begin
      col_new = col_prev + RW'(1);
    end

    row_prev = s1_first_col_r ? RUN_FULL : row_run_r;
    if (col_new != RUN_FULL) begin
      row_new = '0;
    end else if (row_prev >= RUN_FULL - RW'(1)) begin
      row_new = RUN_FULL;
    end else begin
      row_new = row_prev + RW'(1);
    end

    run_sel = (s1_use_cur_r || s1_last_col_r) ? row_new : row_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r <= RUN_FULL;
      row_end_r <= RUN_FULL;
    end else if (s1_adv) begin
      row_run_r <= row_new;
      if (s1_last_col_r) begin
        row_end_r <= row_new;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_emit_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r.mask_value <= (run_sel >= s1_need_r) ? MASK_ON : MASK_OFF;
      out_data_r.out_column <= 11'(s1_oc_r);
      out_data_r.out_row    <= s1_ro_r;
      out_data_r.frame_done <= s1_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/border_roi_mask_erosion_test.sv
// self-checking testbench for the border mask erosion block: register setup, pixel stream, mask check
module border_roi_mask_erosion_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brme_pkg::*;

  localparam int KSIZE         = DEF_KERNEL_SIZE;
  localparam int MAXW          = DEF_MAX_WIDTH;
  localparam int BACK          = KSIZE - 1 - KSIZE / 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 50;
  localparam int RANDOM_PIXELS = 250;
  localparam int NO_LIMIT      = 32'h7fff_ffff;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // mirror of the block state used for prediction
  cfg_t        cfg_shadow;
  logic [4:0]  col_runs [MAXW];
  logic [4:0]  row_run;
  logic [4:0]  row_end_run;
  logic [10:0] in_col;
  logic [12:0] in_row;
  logic [10:0] out_col;
  logic [11:0] out_row;

  out_item_t expected_masks [$];

  int tx_gap_max     = 6;
  int rx_stall_max   = 6;
  int stall_left     = 0;
  int fail_count     = 0;
  int masks_checked  = 0;
  int pixels_sent    = 0;
  int frames_done    = 0;
  int settings_used  = 0;

  border_roi_mask_erosion u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // effective frame geometry after clamping
  function automatic int unsigned frame_cols();
    if (cfg_shadow.frame_width == 0) return 1;
    if (cfg_shadow.frame_width > MAXW) return MAXW;
    return cfg_shadow.frame_width;
  endfunction

  function automatic int unsigned frame_rows();
    return (cfg_shadow.frame_height == 0) ? 1 : cfg_shadow.frame_height;
  endfunction

  function automatic int unsigned bump_run(int unsigned prev, bit ok);
    if (!ok) return 0;
    return (prev + 1 >= KSIZE) ? KSIZE : prev + 1;
  endfunction

  // advance the mirrored erosion pipeline by one transaction; returns 1 when a mask comes out
  function automatic bit predict_mask(input in_item_t item, output out_item_t mask);
    int unsigned w, h, ic, ir, oc, ro, gray, prev, lag, need, reach, run;
    bit pad, on, in_rect, emit, done;
    w = frame_cols();
    h = frame_rows();
    ic = in_col;
    ir = in_row;
    oc = out_col;
    ro = out_row;
    pad = ir >= h;
    done = 1'b0;
    mask = '0;
    if (ic >= w) ic = w - 1;
    if (oc >= w) oc = w - 1;
    // flush inside the frame is dropped
    if (item.opcode == OP_FLUSH && !pad) return 1'b0;

    if (pad) begin
      on = 1'b1;
    end else begin
      gray = item.blue_or_gray;
      if (cfg_shadow.color_input)
        gray = (GRAY_COEF_B * item.blue_or_gray + GRAY_COEF_G * item.green_value +
                GRAY_COEF_R * item.red_value + GRAY_ROUND) >> GRAY_FRAC;
      in_rect = ic >= cfg_shadow.margin_left && ic + cfg_shadow.margin_right < w &&
                ir >= cfg_shadow.margin_top && ir + cfg_shadow.margin_bottom < h;
      on = in_rect && gray != 0;
    end

    // vertical then horizontal run counters
    prev = (ir == 0) ? KSIZE : col_runs[ic];
    col_runs[ic] = 5'(bump_run(prev, on));
    prev = (ic == 0) ? KSIZE : row_run;
    row_run = 5'(bump_run(prev, col_runs[ic] >= KSIZE));
    if (ic == w - 1) row_end_run = row_run;

    lag = (BACK < w - 1) ? BACK : w - 1;
    emit = ir > BACK || (ir == BACK && ic >= lag);
    if (emit) begin
      reach = oc + BACK;
      need = KSIZE;
      run = (ir == ro + BACK) ? row_run : row_end_run;
      if (reach > w - 1) need -= reach - (w - 1);
      done = oc >= w - 1 && ro >= h - 1;
      mask.mask_value = (run >= need) ? MASK_ON : MASK_OFF;
      mask.out_column = 11'(oc);
      mask.out_row    = 12'(ro);
      mask.frame_done = done;
    end

    if (ic >= w - 1) begin
      ic = 0;
      if (ir < IN_ROW_MAX) ir++;
    end else begin
      ic++;
    end

    if (emit) begin
      if (done) begin
        ic = 0; ir = 0; oc = 0; ro = 0;
        frames_done++;
      end else if (oc >= w - 1) begin
        oc = 0;
        ro++;
      end else begin
        oc++;
      end
    end

    in_col  = 11'(ic);
    in_row  = 13'(ir);
    out_col = 11'(oc);
    out_row = 12'(ro);
    return emit;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // mask checker and receiver stall generator
  always @(posedge clk) begin : mask_checker
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      masks_checked++;
      if (expected_masks.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: mask transaction with nothing expected, got col %0d row %0d",
                   $time, out_data.out_column, out_data.out_row);
      end else begin
        want = expected_masks.pop_front();
        if (out_data.mask_value !== want.mask_value)
          note_mismatch("mask_value", want.mask_value, out_data.mask_value);
        if (out_data.out_column !== want.out_column)
          note_mismatch("out_column", want.out_column, out_data.out_column);
        if (out_data.out_row !== want.out_row)
          note_mismatch("out_row", want.out_row, out_data.out_row);
        if (out_data.frame_done !== want.frame_done)
          note_mismatch("frame_done", want.frame_done, out_data.frame_done);
      end
      stall_left = $urandom_range(0, rx_stall_max);
      if (stall_left > 0) out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  // one apb write: setup cycle, then access until pready
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cfg_shadow.frame_width   = value[11:0];
      REG_FRAME_HEIGHT:  cfg_shadow.frame_height  = value[11:0];
      REG_MARGIN_TOP:    cfg_shadow.margin_top    = value[11:0];
      REG_MARGIN_BOTTOM: cfg_shadow.margin_bottom = value[11:0];
      REG_MARGIN_LEFT:   cfg_shadow.margin_left   = value[10:0];
      REG_MARGIN_RIGHT:  cfg_shadow.margin_right  = value[10:0];
      REG_COLOR_INPUT:   cfg_shadow.color_input   = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_geometry(input int w, input int h, input int top, input int bottom,
                                input int left, input int right, input int color);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MARGIN_TOP, top);
    write_reg(REG_MARGIN_BOTTOM, bottom);
    write_reg(REG_MARGIN_LEFT, left);
    write_reg(REG_MARGIN_RIGHT, right);
    write_reg(REG_COLOR_INPUT, color);
    settings_used++;
  endtask

  function automatic in_item_t make_item(input opcode_t op, input logic [7:0] b,
                                         input logic [7:0] g, input logic [7:0] r);
    in_item_t item;
    item.opcode       = op;
    item.blue_or_gray = b;
    item.green_value  = g;
    item.red_value    = r;
    return item;
  endfunction

  // pixel with random channels; zero_pct is the share that must map to gray zero
  function automatic in_item_t random_pixel(input int zero_pct);
    in_item_t p;
    bit zero;
    p = make_item(OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    zero = $urandom_range(0, 99) < zero_pct;
    if (cfg_shadow.color_input) begin
      if (zero) begin
        // small blue and red still round down to gray zero
        p.green_value  = 8'd0;
        p.blue_or_gray = $urandom_range(0, 1);
        p.red_value    = $urandom_range(0, 1);
      end
    end else if (zero) begin
      p.blue_or_gray = 8'd0;
    end else if (p.blue_or_gray == 8'd0) begin
      p.blue_or_gray = 8'd1;
    end
    return p;
  endfunction

  // drive one transaction after a random gap and record its expected mask
  task automatic send_item(input in_item_t item);
    int gap;
    out_item_t mask;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_mask(item, mask)) expected_masks.push_back(mask);
  endtask

  // stop sending and wait until every expected mask has arrived
  task automatic wait_mask_drain();
    in_valid <= 1'b0;
    while (expected_masks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stream a frame: pixels with stray flushes, then padding until the last mask or max_items
  task automatic run_frame(input int zero_pct, input int max_items);
    int start_frames, sent;
    in_item_t item;
    start_frames = frames_done;
    sent = 0;
    while (frames_done == start_frames && sent < max_items) begin
      if (in_row < frame_rows()) begin
        if ($urandom_range(0, 24) == 0) begin
          item = make_item(OP_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
        end else begin
          item = random_pixel(zero_pct);
          pixels_sent++;
        end
      end else begin
        item = make_item(opcode_t'($urandom_range(0, 1)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
      end
      send_item(item);
      sent++;
    end
  endtask

  // zero size taken as one pixel, flush inside the frame, pixels as padding
  task automatic test_directed_corners();
    int k;
    apply_geometry(0, 0, 0, 0, 0, 0, 0);
    send_item(make_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(OP_PIXEL, 8'hFF, 8'h00, 8'h00));
    pixels_sent++;
    k = 0;
    while (in_row != 0) begin
      send_item(make_item(k[0] ? OP_FLUSH : OP_PIXEL, 8'h00, 8'hFF, 8'h00));
      k++;
    end
    wait_mask_drain();
    // color pixel that rounds to gray zero
    apply_geometry(1, 1, 0, 0, 0, 0, 1);
    send_item(make_item(OP_PIXEL, 8'h01, 8'h00, 8'h00));
    pixels_sent++;
    k = 0;
    while (in_row != 0) begin
      send_item(make_item(k[0] ? OP_PIXEL : OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
      k++;
    end
    wait_mask_drain();
  endtask

  // margins that leave no pixel inside
  task automatic test_empty_rectangle();
    apply_geometry(5, 4, 4095, 4095, 2047, 2047, 0);
    run_frame(0, NO_LIMIT);
    wait_mask_drain();
    apply_geometry(6, 3, 0, 0, 3, 3, 1);
    run_frame(0, NO_LIMIT);
    wait_mask_drain();
  endtask

  // narrow the frame and switch to color input after a frame is part way streamed
  task automatic test_width_change();
    apply_geometry(24, 16, 2, 1, 1, 2, 0);
    run_frame(0, 160);
    wait_mask_drain();
    write_reg(REG_FRAME_WIDTH, 9);
    write_reg(REG_COLOR_INPUT, 1);
    run_frame(0, NO_LIMIT);
    wait_mask_drain();
  endtask

  // tall frame, one column wide
  task automatic test_tall_frame();
    apply_geometry(1, 60, 3, 5, 0, 0, 0);
    run_frame(1, NO_LIMIT);
    wait_mask_drain();
  endtask

  // oversized width and zero height, narrowed part way through the first row
  task automatic test_wide_rows();
    tx_gap_max = 0;
    rx_stall_max = 0;
    apply_geometry(4095, 0, 0, 0, 0, 2030, 1);
    run_frame(0, 40);
    wait_mask_drain();
    write_reg(REG_FRAME_WIDTH, 16);
    run_frame(2, NO_LIMIT);
    wait_mask_drain();
    tx_gap_max = 6;
    rx_stall_max = 6;
  endtask

  // random geometry, margins, color mode and content
  task automatic test_random_frames();
    int w, h, top, bottom, left, right, zero_pct, first_pixels;
    first_pixels = pixels_sent;
    while (pixels_sent - first_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0:       w = 0;
        1, 2:    w = $urandom_range(17, 32);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 19))
        0:       h = 0;
        1:       h = $urandom_range(17, 24);
        default: h = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 3))
        0: begin
          top = 0; bottom = 0; left = 0; right = 0;
        end
        1, 2: begin
          top = $urandom_range(0, 3);
          bottom = $urandom_range(0, 3);
          left = $urandom_range(0, 3);
          right = $urandom_range(0, 3);
        end
        default: begin
          top = $urandom_range(0, 4095);
          bottom = $urandom_range(0, 4095);
          left = $urandom_range(0, 2047);
          right = $urandom_range(0, 2047);
        end
      endcase
      apply_geometry(w, h, top, bottom, left, right, $urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0, 1:    zero_pct = 0;
        2:       zero_pct = 2;
        3:       zero_pct = 10;
        default: zero_pct = 50;
      endcase
      repeat ($urandom_range(1, 2)) begin
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        // sometimes hold the sender until the output side has caught up
        if ($urandom_range(0, 5) == 0) begin
          run_frame(zero_pct, $urandom_range(1, 60));
          wait_mask_drain();
        end
        run_frame(zero_pct, NO_LIMIT);
      end
      wait_mask_drain();
    end
  endtask

  // main sequence
  initial begin
    cfg_shadow = '0;
    cfg_shadow.frame_width  = RST_FRAME_WIDTH;
    cfg_shadow.frame_height = RST_FRAME_HEIGHT;
    for (int i = 0; i < MAXW; i++) col_runs[i] = 5'(KSIZE);
    row_run     = 5'(KSIZE);
    row_end_run = 5'(KSIZE);
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_empty_rectangle();
    test_width_change();
    test_tall_frame();
    test_wide_rows();
    test_random_frames();

    $display("covered %0d frames over %0d register settings, incl. empty and clamped geometry",
             frames_done, settings_used);
    $display("%0d pixel transactions sent, %0d mask transactions checked, %0d mismatches",
             pixels_sent, masks_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80_000_000;
    $display("watchdog expired with %0d masks still expected", expected_masks.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
src/brme_pkg.sv
src/brme_apb_regs.sv
src/brme_col_ram.sv
src/border_roi_mask_erosion.sv
dv/border_roi_mask_erosion_test.sv
